[rtl/jetc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the Julia escape-time colorizer.
package jetc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int ITER_WIDTH  = 16;
  localparam int FRAC_BITS   = COORD_WIDTH - 4;
  localparam int MUL_WIDTH   = (COORD_WIDTH < 30) ? 30 : COORD_WIDTH;
  localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
  localparam int T_BITS      = 16;
  localparam int COLOR_WIDTH = 8;
  localparam int RED_SHIFT   = 32;
  localparam int GREEN_SHIFT = 32;
  localparam int BLUE_SHIFT  = 33;
  localparam int IN_WIDTH    = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_WIDTH   = ((3 * COLOR_WIDTH + ITER_WIDTH + 7) / 8) * 8;
  localparam int CFG_WIDTH   = (COORD_WIDTH > ITER_WIDTH) ? COORD_WIDTH : ITER_WIDTH;
  localparam int CFG_IDX_W   = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [MUL_WIDTH-1:0]   mul_op_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic        [ITER_WIDTH-1:0]  iter_t;
  typedef logic        [T_BITS-1:0]      ratio_t;
  typedef logic        [T_BITS:0]        ratio_ext_t;
  typedef logic        [COLOR_WIDTH-1:0] color_t;

  localparam logic [CFG_IDX_W-1:0] REG_C_REAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = CFG_IDX_W'(2);

  localparam coord_t C_REAL_RST = COORD_WIDTH'(-64'sd187904819);
  localparam coord_t C_IMAG_RST = COORD_WIDTH'(64'sd72517838);
  localparam iter_t  LIMIT_RST  = ITER_WIDTH'(1000);

  localparam prod_t ESCAPE_LIMIT = PROD_WIDTH'(1) << (2 * FRAC_BITS + 2);
  localparam prod_t SAT_HI = {{(PROD_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam prod_t SAT_LO = ~SAT_HI;

  localparam mul_op_t K_RED   = MUL_WIDTH'(2295);
  localparam mul_op_t K_GREEN = MUL_WIDTH'(3825);
  localparam mul_op_t K_BLUE  = MUL_WIDTH'(4335);

  // Clamps a wide update sum to the signed coordinate range.
  function automatic coord_t sat_coord(prod_t v);
    coord_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/jetc_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered full-width product.
module jetc_mul (
  input  logic             clk,
  input  jetc_pkg::mul_op_t a,
  input  jetc_pkg::mul_op_t b,
  output jetc_pkg::prod_t   prod
);

  always_ff @(posedge clk) begin
    prod <= jetc_pkg::PROD_WIDTH'(a) * jetc_pkg::PROD_WIDTH'(b);
  end

endmodule

[rtl/jetc_div.sv]
`timescale 1ns / 1ps
// Restoring divider that forms the ratio count / limit one quotient bit per cycle.
module jetc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  jetc_pkg::iter_t        num,
  input  jetc_pkg::iter_t        den,
  output logic                   done,
  output jetc_pkg::ratio_t       quot
);

  localparam int STEP_W = $clog2(jetc_pkg::T_BITS + 1);

  logic                           busy;
  logic [STEP_W-1:0]              steps;
  jetc_pkg::iter_t                rem;
  logic [jetc_pkg::ITER_WIDTH:0]  shifted;
  logic [jetc_pkg::ITER_WIDTH:0]  diff;
  logic                           fits;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= num;
        quot  <= '0;
        steps <= STEP_W'(jetc_pkg::T_BITS);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? diff[jetc_pkg::ITER_WIDTH-1:0] : shifted[jetc_pkg::ITER_WIDTH-1:0];
        quot  <= {quot[jetc_pkg::T_BITS-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/julia_escape_time_colorizer.sv]
`timescale 1ns / 1ps
// Top level of the Julia escape-time colorizer with its sequencer and output register.
//
// Each item on the s_axis channel is one starting point z0; the block iterates
// z = z^2 + c until |z|^2 exceeds 4 or the count reaches iteration_limit, then
// sends one item on the m_axis channel with the pixel color, the iteration count
// and, in tuser, the inside flag.
// All products go through one registered 32 x 32 multiplier. Each iteration
// steps through S_MXX (x*x), S_MYY (y*y), S_MXY (x*y) and S_TEST (the escape
// test and update). An escaped point then goes through the serial divider for
// count/limit and the palette products; an inside point skips both.
// s_axis_tready is high only while no point is in work; one point is handled
// at a time. A finished item sits in the output register, and the next point
// is taken while it waits; if the receiver stalls longer, the block holds its
// next result until the register is free.
// Configuration writes (c_real, c_imag, iteration_limit) take effect at once and
// belong between points. Reset is synchronous; it empties the output register
// and restores the default constant and limit.
module julia_escape_time_colorizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_real, start_imag
  input  logic [jetc_pkg::IN_WIDTH-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red, green, blue, iterations
  output logic [jetc_pkg::OUT_WIDTH-1:0]   m_axis_tdata,
  // inside_res
  output logic                             m_axis_tuser,
  input  logic                             cfg_we,
  input  logic [jetc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jetc_pkg::CFG_WIDTH-1:0]   cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_MXX, S_MYY, S_MXY, S_TEST, S_DIV_GO, S_DIV_WAIT,
    S_TT, S_UT, S_UU, S_R1, S_G1, S_B1, S_R2, S_G2, S_B2, S_BL, S_PUSH
  } state_t;

  localparam int CW = jetc_pkg::COORD_WIDTH;
  localparam int MW = jetc_pkg::MUL_WIDTH;
  localparam int TB = jetc_pkg::T_BITS;

  state_t                  state;
  jetc_pkg::coord_t        x;
  jetc_pkg::coord_t        y;
  jetc_pkg::prod_t         xx;
  jetc_pkg::prod_t         esc_sum;
  jetc_pkg::prod_t         diff;
  jetc_pkg::iter_t         count;
  jetc_pkg::coord_t        c_real;
  jetc_pkg::coord_t        c_imag;
  jetc_pkg::iter_t         limit;
  jetc_pkg::ratio_t        t_r;
  jetc_pkg::ratio_ext_t    u;
  jetc_pkg::ratio_ext_t    tt;
  jetc_pkg::ratio_ext_t    ut;
  jetc_pkg::ratio_ext_t    uu;
  logic [MW-1:0]           tmp_r;
  logic [MW-1:0]           tmp_g;
  logic [MW-1:0]           tmp_b;
  jetc_pkg::color_t        red_w;
  jetc_pkg::color_t        green_w;
  jetc_pkg::color_t        blue_w;
  logic                    inside_w;
  jetc_pkg::mul_op_t       mul_a;
  jetc_pkg::mul_op_t       mul_b;
  jetc_pkg::prod_t         prod;
  logic                    div_start;
  logic                    div_done;
  jetc_pkg::ratio_t        div_quot;
  logic                    escape;
  logic                    stop;
  jetc_pkg::coord_t        x_next;
  jetc_pkg::coord_t        y_next;

  assign s_axis_tready = (state == S_IDLE);
  assign div_start     = (state == S_DIV_GO);
  assign u             = (TB+1)'(1) << TB;
  assign escape        = $unsigned(esc_sum) > $unsigned(jetc_pkg::ESCAPE_LIMIT);
  assign stop          = escape || (count >= limit);
  assign x_next = jetc_pkg::sat_coord((diff >>> jetc_pkg::FRAC_BITS)
                                      + jetc_pkg::PROD_WIDTH'(c_real));
  assign y_next = jetc_pkg::sat_coord((prod >>> (jetc_pkg::FRAC_BITS - 1))
                                      + jetc_pkg::PROD_WIDTH'(c_imag));

  always_comb begin
    mul_a = MW'(x);
    mul_b = MW'(x);
    case (state)
      S_MYY: begin
        mul_a = MW'(y);
        mul_b = MW'(y);
      end
      S_MXY: begin
        mul_a = MW'(x);
        mul_b = MW'(y);
      end
      S_TT: begin
        mul_a = $signed(MW'(t_r));
        mul_b = $signed(MW'(t_r));
      end
      S_UT: begin
        mul_a = $signed(MW'(u - (TB+1)'(t_r)));
        mul_b = $signed(MW'(t_r));
      end
      S_UU: begin
        mul_a = $signed(MW'(u - (TB+1)'(t_r)));
        mul_b = $signed(MW'(u - (TB+1)'(t_r)));
      end
      S_R1: begin
        mul_a = jetc_pkg::K_RED;
        mul_b = $signed(MW'(ut));
      end
      S_G1: begin
        mul_a = jetc_pkg::K_GREEN;
        mul_b = $signed(MW'(uu));
      end
      S_B1: begin
        mul_a = jetc_pkg::K_BLUE;
        mul_b = $signed(MW'(uu));
      end
      S_R2: begin
        mul_a = $signed(tmp_r);
        mul_b = $signed(MW'(tt));
      end
      S_G2: begin
        mul_a = $signed(tmp_g);
        mul_b = $signed(MW'(tt));
      end
      S_B2: begin
        mul_a = $signed(tmp_b);
        mul_b = $signed(MW'(ut));
      end
      default: begin
        mul_a = MW'(x);
        mul_b = MW'(x);
      end
    endcase
  end

  jetc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  jetc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (count),
    .den   (limit),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      c_real        <= jetc_pkg::C_REAL_RST;
      c_imag        <= jetc_pkg::C_IMAG_RST;
      limit         <= jetc_pkg::LIMIT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jetc_pkg::REG_C_REAL: c_real <= cfg_wdata[CW-1:0];
          jetc_pkg::REG_C_IMAG: c_imag <= cfg_wdata[CW-1:0];
          jetc_pkg::REG_LIMIT:  limit  <= cfg_wdata[jetc_pkg::ITER_WIDTH-1:0];
          default: ;
        endcase
      end

      if (m_axis_tready && (state != S_PUSH)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x     <= s_axis_tdata[CW-1:0];
            y     <= s_axis_tdata[2*CW-1:CW];
            count <= '0;
            state <= S_MXX;
          end
        end
        S_MXX: state <= S_MYY;
        S_MYY: begin
          xx    <= prod;
          state <= S_MXY;
        end
        S_MXY: begin
          esc_sum <= xx + prod;
          diff    <= xx - prod;
          state   <= S_TEST;
        end
        S_TEST: begin
          if (stop) begin
            if (count == limit) begin
              inside_w <= 1'b1;
              red_w    <= '0;
              green_w  <= '0;
              blue_w   <= '0;
              state    <= S_PUSH;
            end else begin
              inside_w <= 1'b0;
              state    <= S_DIV_GO;
            end
          end else begin
            x     <= x_next;
            y     <= y_next;
            count <= count + jetc_pkg::ITER_WIDTH'(1);
            state <= S_MXX;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            t_r   <= div_quot;
            state <= S_TT;
          end
        end
        S_TT: state <= S_UT;
        S_UT: begin
          tt    <= prod[TB +: TB+1];
          state <= S_UU;
        end
        S_UU: begin
          ut    <= prod[TB +: TB+1];
          state <= S_R1;
        end
        S_R1: begin
          uu    <= prod[TB +: TB+1];
          state <= S_G1;
        end
        S_G1: begin
          tmp_r <= prod[MW-1:0];
          state <= S_B1;
        end
        S_B1: begin
          tmp_g <= prod[MW-1:0];
          state <= S_R2;
        end
        S_R2: begin
          tmp_b <= prod[MW-1:0];
          state <= S_G2;
        end
        S_G2: begin
          red_w <= prod[jetc_pkg::RED_SHIFT +: jetc_pkg::COLOR_WIDTH];
          state <= S_B2;
        end
        S_B2: begin
          green_w <= prod[jetc_pkg::GREEN_SHIFT +: jetc_pkg::COLOR_WIDTH];
          state   <= S_BL;
        end
        S_BL: begin
          blue_w <= prod[jetc_pkg::BLUE_SHIFT +: jetc_pkg::COLOR_WIDTH];
          state  <= S_PUSH;
        end
        S_PUSH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= jetc_pkg::OUT_WIDTH'({count, blue_w, green_w, red_w});
            m_axis_tuser  <= inside_w;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/jetc_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the Julia escape-time colorizer and their bind.
module jetc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [jetc_pkg::OUT_WIDTH-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  localparam int COLOR_BITS = 3 * jetc_pkg::COLOR_WIDTH;

  // An inside point is always black.
  a_inside_black: assert property (@(posedge clk)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[COLOR_BITS-1:0] == '0))
    else $error("inside item carries a nonzero color");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output item present right after reset");

  // Once a point is taken, the block is busy with it in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk)
    (s_axis_tvalid && s_axis_tready && !rst) |=> !s_axis_tready)
    else $error("ready stayed high after an accepted item");

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                          && $stable(m_axis_tuser)))
    else $error("stalled output item changed");

endmodule

bind julia_escape_time_colorizer jetc_checker u_jetc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
